// ----- rtl/quaternion_vector_rotate_core_assert.svh -----
// assertion macros shared by the rotator modules
// both expect clk and arst_n in the enclosing scope
`ifndef QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define QVR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/qvr_pkg.sv -----
package qvr_pkg;

	// field width of vectors, quaternion parts and outputs
	localparam int FIELD_W = 16;
	// first product terms and their sums
	localparam int P1_W = 2 * FIELD_W;
	localparam int T_W = P1_W + 1;
	// second product terms, pair sums and totals
	localparam int P2_W = T_W + FIELD_W;
	localparam int R_W = P2_W + 1;
	// fixed point scale of the full sandwich product
	localparam int FRAC_SHIFT = 28;

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [P1_W-1:0] prod1_t;
	typedef logic signed [T_W-1:0] tval_t;
	typedef logic signed [P2_W-1:0] prod2_t;
	typedef logic signed [R_W-1:0] rval_t;

endpackage

// ----- rtl/qvr_channels.sv -----
// input beat: vector and quaternion
interface qvr_item_if;
	logic valid;
	logic ready;
	qvr_pkg::field_t vec_x;
	qvr_pkg::field_t vec_y;
	qvr_pkg::field_t vec_z;
	qvr_pkg::field_t quat_w;
	qvr_pkg::field_t quat_x;
	qvr_pkg::field_t quat_y;
	qvr_pkg::field_t quat_z;
	modport source (output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
		input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
		output ready);
endinterface

// output beat: rotated vector and saturation flag
interface qvr_result_if;
	logic valid;
	logic ready;
	qvr_pkg::field_t out_x;
	qvr_pkg::field_t out_y;
	qvr_pkg::field_t out_z;
	logic clipped;
	modport source (output valid, out_x, out_y, out_z, clipped, input ready);
	modport sink (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// q * (v, 0) with the quaternion carried alongside
interface qvr_t_if;
	logic valid;
	logic ready;
	qvr_pkg::tval_t t_w;
	qvr_pkg::tval_t t_x;
	qvr_pkg::tval_t t_y;
	qvr_pkg::tval_t t_z;
	qvr_pkg::field_t q_w;
	qvr_pkg::field_t q_x;
	qvr_pkg::field_t q_y;
	qvr_pkg::field_t q_z;
	modport source (output valid, t_w, t_x, t_y, t_z, q_w, q_x, q_y, q_z, input ready);
	modport sink (input valid, t_w, t_x, t_y, t_z, q_w, q_x, q_y, q_z, output ready);
endinterface

// full precision vector part of the sandwich product
interface qvr_r_if;
	logic valid;
	logic ready;
	qvr_pkg::rval_t r_x;
	qvr_pkg::rval_t r_y;
	qvr_pkg::rval_t r_z;
	modport source (output valid, r_x, r_y, r_z, input ready);
	modport sink (input valid, r_x, r_y, r_z, output ready);
endinterface

// ----- rtl/qvr_tprod.sv -----
// first hamilton product t = q * (v, 0): products in s1, sums in s2
module qvr_tprod (
	input logic clk,
	input logic arst_n,
	qvr_item_if.sink up,
	qvr_t_if.source dn
);

	logic v_s1, v_s2;
	logic en_s1, en_s2;

	qvr_pkg::prod1_t qx_vx_s1, qy_vy_s1, qz_vz_s1;
	qvr_pkg::prod1_t qw_vx_s1, qy_vz_s1, qz_vy_s1;
	qvr_pkg::prod1_t qw_vy_s1, qx_vz_s1, qz_vx_s1;
	qvr_pkg::prod1_t qw_vz_s1, qx_vy_s1, qy_vx_s1;
	qvr_pkg::field_t q_w_s1, q_x_s1, q_y_s1, q_z_s1;

	qvr_pkg::tval_t t_w_s2, t_x_s2, t_y_s2, t_z_s2;
	qvr_pkg::field_t q_w_s2, q_x_s2, q_y_s2, q_z_s2;

	// a stage moves when it is empty or its successor moves
	assign en_s2 = !v_s2 || dn.ready;
	assign en_s1 = !v_s1 || en_s2;
	assign up.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= up.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			qx_vx_s1 <= qvr_pkg::prod1_t'(up.quat_x) * qvr_pkg::prod1_t'(up.vec_x);
			qy_vy_s1 <= qvr_pkg::prod1_t'(up.quat_y) * qvr_pkg::prod1_t'(up.vec_y);
			qz_vz_s1 <= qvr_pkg::prod1_t'(up.quat_z) * qvr_pkg::prod1_t'(up.vec_z);
			qw_vx_s1 <= qvr_pkg::prod1_t'(up.quat_w) * qvr_pkg::prod1_t'(up.vec_x);
			qy_vz_s1 <= qvr_pkg::prod1_t'(up.quat_y) * qvr_pkg::prod1_t'(up.vec_z);
			qz_vy_s1 <= qvr_pkg::prod1_t'(up.quat_z) * qvr_pkg::prod1_t'(up.vec_y);
			qw_vy_s1 <= qvr_pkg::prod1_t'(up.quat_w) * qvr_pkg::prod1_t'(up.vec_y);
			qx_vz_s1 <= qvr_pkg::prod1_t'(up.quat_x) * qvr_pkg::prod1_t'(up.vec_z);
			qz_vx_s1 <= qvr_pkg::prod1_t'(up.quat_z) * qvr_pkg::prod1_t'(up.vec_x);
			qw_vz_s1 <= qvr_pkg::prod1_t'(up.quat_w) * qvr_pkg::prod1_t'(up.vec_z);
			qx_vy_s1 <= qvr_pkg::prod1_t'(up.quat_x) * qvr_pkg::prod1_t'(up.vec_y);
			qy_vx_s1 <= qvr_pkg::prod1_t'(up.quat_y) * qvr_pkg::prod1_t'(up.vec_x);
			q_w_s1 <= up.quat_w;
			q_x_s1 <= up.quat_x;
			q_y_s1 <= up.quat_y;
			q_z_s1 <= up.quat_z;
		end
		if (en_s2) begin
			t_w_s2 <= -(qvr_pkg::tval_t'(qx_vx_s1) + qvr_pkg::tval_t'(qy_vy_s1)
				+ qvr_pkg::tval_t'(qz_vz_s1));
			t_x_s2 <= qvr_pkg::tval_t'(qw_vx_s1) + qvr_pkg::tval_t'(qy_vz_s1)
				- qvr_pkg::tval_t'(qz_vy_s1);
			t_y_s2 <= qvr_pkg::tval_t'(qw_vy_s1) - qvr_pkg::tval_t'(qx_vz_s1)
				+ qvr_pkg::tval_t'(qz_vx_s1);
			t_z_s2 <= qvr_pkg::tval_t'(qw_vz_s1) + qvr_pkg::tval_t'(qx_vy_s1)
				- qvr_pkg::tval_t'(qy_vx_s1);
			q_w_s2 <= q_w_s1;
			q_x_s2 <= q_x_s1;
			q_y_s2 <= q_y_s1;
			q_z_s2 <= q_z_s1;
		end
	end

	assign dn.valid = v_s2;
	assign dn.t_w = t_w_s2;
	assign dn.t_x = t_x_s2;
	assign dn.t_y = t_y_s2;
	assign dn.t_z = t_z_s2;
	assign dn.q_w = q_w_s2;
	assign dn.q_x = q_x_s2;
	assign dn.q_y = q_y_s2;
	assign dn.q_z = q_z_s2;

endmodule

// ----- rtl/qvr_rprod.sv -----
`include "quaternion_vector_rotate_core_assert.svh"

// second hamilton product r = t * conj(q), vector part
// products in s3, pair sums in s4, totals in s5
module qvr_rprod (
	input logic clk,
	input logic arst_n,
	qvr_t_if.sink up,
	qvr_r_if.source dn
);

	logic v_s3, v_s4, v_s5;
	logic en_s3, en_s4, en_s5;

	qvr_pkg::prod2_t tw_qx_s3, tx_qw_s3, ty_qz_s3, tz_qy_s3;
	qvr_pkg::prod2_t tw_qy_s3, tx_qz_s3, ty_qw_s3, tz_qx_s3;
	qvr_pkg::prod2_t tw_qz_s3, tx_qy_s3, ty_qx_s3, tz_qw_s3;

	qvr_pkg::prod2_t rx_a_s4, rx_b_s4, ry_a_s4, ry_b_s4, rz_a_s4, rz_b_s4;

	qvr_pkg::rval_t r_x_s5, r_y_s5, r_z_s5;

	assign en_s5 = !v_s5 || dn.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign up.ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= up.valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			tw_qx_s3 <= qvr_pkg::prod2_t'(up.t_w) * qvr_pkg::prod2_t'(up.q_x);
			tx_qw_s3 <= qvr_pkg::prod2_t'(up.t_x) * qvr_pkg::prod2_t'(up.q_w);
			ty_qz_s3 <= qvr_pkg::prod2_t'(up.t_y) * qvr_pkg::prod2_t'(up.q_z);
			tz_qy_s3 <= qvr_pkg::prod2_t'(up.t_z) * qvr_pkg::prod2_t'(up.q_y);
			tw_qy_s3 <= qvr_pkg::prod2_t'(up.t_w) * qvr_pkg::prod2_t'(up.q_y);
			tx_qz_s3 <= qvr_pkg::prod2_t'(up.t_x) * qvr_pkg::prod2_t'(up.q_z);
			ty_qw_s3 <= qvr_pkg::prod2_t'(up.t_y) * qvr_pkg::prod2_t'(up.q_w);
			tz_qx_s3 <= qvr_pkg::prod2_t'(up.t_z) * qvr_pkg::prod2_t'(up.q_x);
			tw_qz_s3 <= qvr_pkg::prod2_t'(up.t_w) * qvr_pkg::prod2_t'(up.q_z);
			tx_qy_s3 <= qvr_pkg::prod2_t'(up.t_x) * qvr_pkg::prod2_t'(up.q_y);
			ty_qx_s3 <= qvr_pkg::prod2_t'(up.t_y) * qvr_pkg::prod2_t'(up.q_x);
			tz_qw_s3 <= qvr_pkg::prod2_t'(up.t_z) * qvr_pkg::prod2_t'(up.q_w);
		end
		// each term is at most 3*2^45 in magnitude, so a difference of two fits the product width
		if (en_s4) begin
			rx_a_s4 <= tx_qw_s3 - tw_qx_s3;
			rx_b_s4 <= tz_qy_s3 - ty_qz_s3;
			ry_a_s4 <= tx_qz_s3 - tw_qy_s3;
			ry_b_s4 <= ty_qw_s3 - tz_qx_s3;
			rz_a_s4 <= ty_qx_s3 - tw_qz_s3;
			rz_b_s4 <= tz_qw_s3 - tx_qy_s3;
		end
		if (en_s5) begin
			r_x_s5 <= qvr_pkg::rval_t'(rx_a_s4) + qvr_pkg::rval_t'(rx_b_s4);
			r_y_s5 <= qvr_pkg::rval_t'(ry_a_s4) + qvr_pkg::rval_t'(ry_b_s4);
			r_z_s5 <= qvr_pkg::rval_t'(rz_a_s4) + qvr_pkg::rval_t'(rz_b_s4);
		end
	end

	assign dn.valid = v_s5;
	assign dn.r_x = r_x_s5;
	assign dn.r_y = r_y_s5;
	assign dn.r_z = r_z_s5;

	`QVR_ASSERT_NEXT(a_s3_load, up.valid && up.ready, v_s3, "accepted beat not held in s3")

endmodule

// ----- rtl/qvr_round.sv -----
`include "quaternion_vector_rotate_core_assert.svh"

// round to nearest (ties up), saturate, and hold the output beat (s6)
module qvr_round (
	input logic clk,
	input logic arst_n,
	qvr_r_if.sink up,
	qvr_result_if.source dn
);

	localparam int QUO_W = qvr_pkg::R_W - qvr_pkg::FRAC_SHIFT;

	typedef logic signed [QUO_W-1:0] quo_t;
	typedef struct packed {
		qvr_pkg::field_t value;
		logic clip;
	} sat_t;

	localparam qvr_pkg::rval_t HALF = qvr_pkg::rval_t'(1) << (qvr_pkg::FRAC_SHIFT - 1);
	localparam qvr_pkg::field_t FIELD_MAX = {1'b0, {(qvr_pkg::FIELD_W - 1){1'b1}}};
	localparam qvr_pkg::field_t FIELD_MIN = {1'b1, {(qvr_pkg::FIELD_W - 1){1'b0}}};

	function automatic sat_t round_sat(input qvr_pkg::rval_t r);
		qvr_pkg::rval_t biased;
		quo_t quo;
		sat_t res;
		biased = r + HALF;
		quo = quo_t'(biased >>> qvr_pkg::FRAC_SHIFT);
		if (quo > quo_t'(FIELD_MAX)) begin
			res.value = FIELD_MAX;
			res.clip = 1'b1;
		end else if (quo < quo_t'(FIELD_MIN)) begin
			res.value = FIELD_MIN;
			res.clip = 1'b1;
		end else begin
			res.value = quo[qvr_pkg::FIELD_W-1:0];
			res.clip = 1'b0;
		end
		return res;
	endfunction

	logic v_s6;
	logic en_s6;
	sat_t sx, sy, sz;
	qvr_pkg::field_t out_x_s6, out_y_s6, out_z_s6;
	logic clipped_s6;

	assign en_s6 = !v_s6 || dn.ready;
	assign up.ready = en_s6;

	assign sx = round_sat(up.r_x);
	assign sy = round_sat(up.r_y);
	assign sz = round_sat(up.r_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			out_x_s6 <= sx.value;
			out_y_s6 <= sy.value;
			out_z_s6 <= sz.value;
			clipped_s6 <= sx.clip | sy.clip | sz.clip;
		end
	end

	assign dn.valid = v_s6;
	assign dn.out_x = out_x_s6;
	assign dn.out_y = out_y_s6;
	assign dn.out_z = out_z_s6;
	assign dn.clipped = clipped_s6;

	`QVR_ASSERT_SAME(a_clip_at_rail, dn.valid && dn.clipped, dn.out_x == FIELD_MAX || dn.out_x == FIELD_MIN || dn.out_y == FIELD_MAX || dn.out_y == FIELD_MIN || dn.out_z == FIELD_MAX || dn.out_z == FIELD_MIN, "clipped set with no part at a rail")
	`QVR_ASSERT_NEXT(a_out_load, up.valid && up.ready, dn.valid, "accepted beat not presented")

endmodule

// ----- rtl/quaternion_vector_rotate_core.sv -----
// Quaternion vector rotation: each item beat carries a vector (signed integers) and a
// quaternion (signed Q2.14) and yields one result beat holding the vector part of
// q * (v, 0) * conj(q), formed exactly, rounded to nearest with ties upward and
// saturated to 16 bits; clipped flags a saturated part. The quaternion is not
// normalised, so a non-unit quaternion scales the result by its squared norm. The
// core takes one beat per clock unless back-pressure on result fills the pipe, using
// six register stages (s1..s6), each a multiplier rank, an adder rank or the rounding.
// Back-pressure on result stops only the stages behind a held beat: empty stages keep
// filling, and item.ready drops only when all six stages hold beats and result is not
// taken, so item.ready follows result.ready combinationally. Reset clears only the
// stage valid bits; there is no clearing pass and no configuration.
`include "quaternion_vector_rotate_core_assert.svh"

module quaternion_vector_rotate_core (
	input logic clk,
	input logic arst_n,
	qvr_item_if.sink item,
	qvr_result_if.source result
);

	// links between the pipeline sections
	qvr_t_if t_link ();
	qvr_r_if r_link ();

	// s1 products of q and v, s2 the four parts of t = q * (v, 0)
	qvr_tprod u_tprod (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (item),
		.dn     (t_link)
	);

	// s3 products of t and q, s4 pair sums, s5 full precision vector part
	qvr_rprod u_rprod (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (t_link),
		.dn     (r_link)
	);

	// s6 rounding, saturation and the output register
	qvr_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (r_link),
		.dn     (result)
	);

	// a full pipe with a held result is the only reason to refuse a beat
	`QVR_ASSERT_SAME(a_stall_cause, !item.ready, result.valid && !result.ready && r_link.valid && t_link.valid, "item refused while the pipe can move")

endmodule

// ----- dv/tb_quaternion_vector_rotate_core.sv -----
module tb_quaternion_vector_rotate_core;
	typedef qvr_pkg::field_t field_t;
	localparam int FRAC_SHIFT = qvr_pkg::FRAC_SHIFT;

	// one input beat: vector to turn and the quaternion that turns it
	typedef struct packed {
		field_t vec_x;
		field_t vec_y;
		field_t vec_z;
		field_t quat_w;
		field_t quat_x;
		field_t quat_y;
		field_t quat_z;
	} vec_quat_t;

	// one result beat
	typedef struct packed {
		field_t x;
		field_t y;
		field_t z;
		logic clipped;
	} rotated_t;

	// directed row: result typed in only where it can be read off by eye
	typedef struct {
		vec_quat_t stim;
		bit typed;
		rotated_t want;
	} directed_row_t;

	localparam int N_DIRECTED = 18;
	localparam int N_RANDOM = 800;
	localparam int DRAIN_CYCLES = 20;
	localparam int CLK_HALF = 10;
	localparam int RUN_LIMIT = 200000 * 2 * CLK_HALF;

	// q = 1.0 in Q2.14
	localparam field_t ONE = 16384;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qvr_item_if item_if ();
	qvr_result_if result_if ();

	rotated_t rotated_due[$];
	int mismatches = 0;
	int send_calm = 0;
	int take_calm = 0;

	quaternion_vector_rotate_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if)
	);

	always #(CLK_HALF) clk = ~clk;

	// identities, extremes, saturation, negative ties and half-turns about each axis;
	// rows not typed in are left to the predictor
	directed_row_t directed[N_DIRECTED] = '{
		'{'{100, -200, 300, ONE, 0, 0, 0}, 1'b1, '{100, -200, 300, 1'b0}},
		'{'{32767, -32768, 0, ONE, 0, 0, 0}, 1'b1, '{32767, -32768, 0, 1'b0}},
		// zero quaternion wipes the vector out, no clipping
		'{'{32767, -32768, -32768, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}},
		// w = -2.0 scales by four, the big part saturates
		'{'{1, -1, 32767, -32768, 0, 0, 0}, 1'b1, '{4, -4, 32767, 1'b1}},
		'{'{0, -32768, 0, -32768, 0, 0, 0}, 1'b1, '{0, -32768, 0, 1'b1}},
		// half-turn about x keeps x and negates y and z
		'{'{5, 7, -9, 0, ONE, 0, 0}, 1'b1, '{5, -7, 9, 1'b0}},
		'{'{0, -32768, 0, 0, ONE, 0, 0}, 1'b1, '{0, 32767, 0, 1'b1}},
		// half-turn about y, negated -32768 has to clip
		'{'{-32768, 3, 4, 0, 0, ONE, 0}, 1'b1, '{32767, 3, -4, 1'b1}},
		'{'{11, -12, 13, 0, 0, 0, ONE}, 1'b1, '{-11, 12, 13, 1'b0}},
		// w = 0.5 gives a quarter scale: -0.5 goes to 0, 0.5 to 1, -1.5 to -1
		'{'{-2, 2, -6, 8192, 0, 0, 0}, 1'b1, '{0, 1, -1, 1'b0}},
		'{'{2, -2, -2, 0, 0, 0, 8192}, 1'b1, '{0, 1, 0, 1'b0}},
		'{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768}, 1'b0, '{0, 0, 0, 1'b0}},
		'{'{32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, '{0, 0, 0, 1'b0}},
		'{'{-32768, 32767, -32768, 32767, -32768, 32767, -32768}, 1'b0, '{0, 0, 0, 1'b0}},
		// quarter-turn about z, inexact quaternion
		'{'{1000, 0, 0, 11585, 0, 0, 11585}, 1'b0, '{0, 0, 0, 1'b0}},
		'{'{-1, -1, -1, -1, -1, -1, -1}, 1'b0, '{0, 0, 0, 1'b0}},
		'{'{32767, -32768, 12345, 1, 0, 0, 0}, 1'b0, '{0, 0, 0, 1'b0}},
		// third of a turn about the diagonal
		'{'{1, 2, 3, 8192, 8192, 8192, 8192}, 1'b0, '{0, 0, 0, 1'b0}}
	};

	// shift down by the fixed point scale, ties upward, then clamp to 16 bits
	function automatic field_t round_clamp(input longint r, inout logic clip);
		longint q;
		q = (r + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
		if (q > 32767) begin
			q = 32767;
			clip = 1'b1;
		end else if (q < -32768) begin
			q = -32768;
			clip = 1'b1;
		end
		return field_t'(q);
	endfunction

	// vector part of q * (v, 0) * conj(q), exact in 64 bits
	function automatic rotated_t rotate_by_quat(input vec_quat_t b);
		longint vx, vy, vz, qw, qx, qy, qz;
		longint tw, tx, ty, tz;
		longint rx, ry, rz;
		rotated_t res;
		logic clip;
		vx = b.vec_x;
		vy = b.vec_y;
		vz = b.vec_z;
		qw = b.quat_w;
		qx = b.quat_x;
		qy = b.quat_y;
		qz = b.quat_z;
		tw = -(qx * vx + qy * vy + qz * vz);
		tx = qw * vx + qy * vz - qz * vy;
		ty = qw * vy - qx * vz + qz * vx;
		tz = qw * vz + qx * vy - qy * vx;
		rx = -tw * qx + tx * qw - ty * qz + tz * qy;
		ry = -tw * qy + tx * qz + ty * qw - tz * qx;
		rz = -tw * qz - tx * qy + ty * qx + tz * qw;
		clip = 1'b0;
		res.x = round_clamp(rx, clip);
		res.y = round_clamp(ry, clip);
		res.z = round_clamp(rz, clip);
		res.clipped = clip;
		return res;
	endfunction

	function automatic field_t pick(input int lo, input int hi);
		return field_t'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	function automatic field_t corner();
		case ($urandom_range(0, 6))
			0: return -32768;
			1: return -16384;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 16384;
			default: return 32767;
		endcase
	endfunction

	// random wait before a beat, with calm stretches of back-to-back beats
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 17);
	endfunction

	function automatic vec_quat_t random_beat();
		vec_quat_t b;
		real n2, s;
		int pw, px, py, pz;
		b.vec_x = field_t'($urandom);
		b.vec_y = field_t'($urandom);
		b.vec_z = field_t'($urandom);
		case ($urandom_range(0, 99)) inside
			[0:44]: begin
				// proper rotations: random axis and angle, scaled to unit norm
				pw = pick(-ONE, ONE);
				px = pick(-ONE, ONE);
				py = pick(-ONE, ONE);
				pz = pick(-ONE, ONE);
				n2 = real'(pw) * pw + real'(px) * px + real'(py) * py + real'(pz) * pz;
				if (n2 == 0.0) begin
					pw = ONE;
					n2 = real'(ONE) * ONE;
				end
				s = real'(ONE) / $sqrt(n2);
				b.quat_w = field_t'(int'(pw * s));
				b.quat_x = field_t'(int'(px * s));
				b.quat_y = field_t'(int'(py * s));
				b.quat_z = field_t'(int'(pz * s));
			end
			[45:64]: begin
				// anything at all, mostly clipped
				b.quat_w = field_t'($urandom);
				b.quat_x = field_t'($urandom);
				b.quat_y = field_t'($urandom);
				b.quat_z = field_t'($urandom);
			end
			[65:79]: begin
				// tiny quaternions, results near zero where the rounding matters
				b.quat_w = pick(-200, 200);
				b.quat_x = pick(-200, 200);
				b.quat_y = pick(-200, 200);
				b.quat_z = pick(-200, 200);
				if ($urandom_range(0, 1))
					b.vec_x = pick(-8, 8);
			end
			default: begin
				// corners of each part, with corner vectors now and then
				b.quat_w = corner();
				b.quat_x = corner();
				b.quat_y = corner();
				b.quat_z = corner();
				if ($urandom_range(0, 2) == 0) begin
					b.vec_x = corner();
					b.vec_y = corner();
					b.vec_z = corner();
				end
			end
		endcase
		return b;
	endfunction

	// holds the beat on the item channel until it is taken, then files its result
	task automatic send_beat(input vec_quat_t b, input rotated_t want);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.vec_x <= b.vec_x;
		item_if.vec_y <= b.vec_y;
		item_if.vec_z <= b.vec_z;
		item_if.quat_w <= b.quat_w;
		item_if.quat_x <= b.quat_x;
		item_if.quat_y <= b.quat_y;
		item_if.quat_z <= b.quat_z;
		do @(posedge clk); while (!item_if.ready);
		// taken at this edge; the result still has to pass the pipeline registers
		rotated_due.push_back(want);
	endtask

	task automatic report(input string part, input int want, input int got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, part, want, got);
		mismatches++;
	endtask

	// result side: stalls drawn per beat, ready held until a beat goes through
	initial begin
		int stall;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(take_calm);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
		end
	end

	// every result beat against the oldest outstanding rotation
	always @(posedge clk) begin
		rotated_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (rotated_due.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got %0d %0d %0d %0b",
					$time, result_if.out_x, result_if.out_y, result_if.out_z,
					result_if.clipped);
				mismatches++;
			end else begin
				want = rotated_due.pop_front();
				if (result_if.out_x !== want.x)
					report("out_x", want.x, result_if.out_x);
				if (result_if.out_y !== want.y)
					report("out_y", want.y, result_if.out_y);
				if (result_if.out_z !== want.z)
					report("out_z", want.z, result_if.out_z);
				if (result_if.clipped !== want.clipped)
					report("clipped", want.clipped, result_if.clipped);
			end
		end
	end

	// stimulus: directed table first, then the random beats, then drain
	initial begin
		vec_quat_t b;
		item_if.valid = 1'b0;
		item_if.vec_x = '0;
		item_if.vec_y = '0;
		item_if.vec_z = '0;
		item_if.quat_w = '0;
		item_if.quat_x = '0;
		item_if.quat_y = '0;
		item_if.quat_z = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_beat(directed[i].stim,
				directed[i].typed ? directed[i].want : rotate_by_quat(directed[i].stim));
		for (int n = 0; n < N_RANDOM; n++) begin
			b = random_beat();
			send_beat(b, rotate_by_quat(b));
		end
		item_if.valid <= 1'b0;
		while (rotated_due.size() != 0)
			@(posedge clk);
		// a little longer than the six-stage pipe so strays would show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_quaternion_vector_rotate_core passed");
		else
			$display("tb_quaternion_vector_rotate_core failed");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#(RUN_LIMIT);
		$display("tb_quaternion_vector_rotate_core failed");
		$finish;
	end

endmodule
